// ===== hdl/line_substring_matcher_macros.svh =====
// Assertion macros for the line substring matcher RTL.
// No dependencies; included by line_substring_matcher.sv, which carries concurrent assertions.
`ifndef LINE_SUBSTRING_MATCHER_MACROS_SVH
`define LINE_SUBSTRING_MATCHER_MACROS_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define LSM_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Assertion on the default clock and reset names of this project.
`define LSM_ASSERT(label, prop, msg) \
  `LSM_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// ===== hdl/lsm_pkg.sv =====
// Package for the line substring matcher: widths, codes and shared types.
// No dependencies; imported by lsm_cell and line_substring_matcher.
`timescale 1ns / 1ps
`default_nettype none

package lsm_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 5;
  localparam int unsigned PAT_W  = 64;
  localparam int unsigned LINE_W = 32;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 64;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [PAT_W-1:0]  pat_t;
  typedef logic [LINE_W-1:0] line_t;

  localparam byte_t NEWLINE_BYTE = 8'd10;

  // Register index, taken from the doubleword address bits.
  typedef enum logic [1:0] {
    REG_LENGTH = 2'd0,
    REG_LOW    = 2'd1,
    REG_HIGH   = 2'd2
  } cfg_reg_e;

  // What one cell reports about the byte it is about to hold.
  typedef struct packed {
    logic valid;  // the byte belongs to the current line
    logic eq;     // the byte equals the pattern byte aligned to this cell
  } cell_status_t;

endpackage

`default_nettype wire

// ===== hdl/lsm_cell.sv =====
// One window cell of the line substring matcher: a text byte and its valid bit.
// Depends on lsm_pkg; instantiated in a chain by line_substring_matcher.
`timescale 1ns / 1ps
`default_nettype none

module lsm_cell (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       shift_i,
  input  wire                       clear_i,
  input  lsm_pkg::byte_t            byte_i,
  input  wire                       valid_i,
  input  lsm_pkg::byte_t            pat_i,
  output lsm_pkg::byte_t            byte_o,
  output logic                      valid_o,
  output lsm_pkg::cell_status_t     status_o
);
  import lsm_pkg::*;

  byte_t win_q;
  logic  vld_q;

  // The byte payload needs no reset; the valid bit hides it.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      win_q <= byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (clear_i) begin
      vld_q <= 1'b0;
    end else if (shift_i) begin
      vld_q <= valid_i;
    end
  end

  // Status refers to the incoming byte, i.e. the window after this shift.
  assign status_o.valid = valid_i;
  assign status_o.eq    = (byte_i == pat_i);

  assign byte_o  = win_q;
  assign valid_o = vld_q;

endmodule

`default_nettype wire

// ===== hdl/line_substring_matcher.sv =====
// Line substring matcher top level: APB register file, cell chain, output stage.
// Depends on lsm_pkg, lsm_cell and line_substring_matcher_macros.svh.
//
// Usage: text enters one byte per transaction on the in channel (in_valid_i,
// in_ready_o, text_byte_i). A byte of value 10 ends a line. The first time in
// a line that the newest bytes equal the configured pattern, one transaction
// leaves on the out channel (out_valid_o, out_ready_i, line_number_o) with the
// number of that line; lines count from 1 and saturate at all ones.
// The pattern and its length are set over the APB port before text is sent.
// Throughput: one byte per cycle when no result is stalled, set by the shift
// of the cell chain and the parallel compare of all cells against the aligned
// pattern. Latency: the result appears in the cycle after the byte that
// completes the match was accepted.
// Stalls: a pending result sits in the output register; input bytes are still
// taken while out_ready_i is high or no result is pending, and the input is
// held off only while a result waits and the receiver is not ready.
// Reset: asynchronous, active low. It empties the window, clears the found
// flag, sets the line number to 1 and the pattern length register to 1 with
// both pattern registers zero. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

`include "line_substring_matcher_macros.svh"

module line_substring_matcher #(
  parameter int unsigned MAX_PATTERN = 16
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  // Text input channel.
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  lsm_pkg::byte_t         text_byte_i,
  // Result channel.
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output lsm_pkg::line_t         line_number_o,
  // APB configuration port.
  input  wire                    psel,
  input  wire                    penable,
  input  wire                    pwrite,
  input  wire [lsm_pkg::ADDR_W-1:0] paddr,
  input  wire [lsm_pkg::DATA_W-1:0] pwdata,
  output logic [lsm_pkg::DATA_W-1:0] prdata,
  output logic                   pready
);
  import lsm_pkg::*;

  // ---------------------------------------------------------------------
  // Configuration registers. Register i sits at byte address 8*i, so the
  // index is taken from paddr[4:3]; the fourth slot is unmapped.
  // ---------------------------------------------------------------------
  len_t pat_len_q;
  pat_t pat_low_q;
  pat_t pat_high_q;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len_q  <= len_t'(1);
      pat_low_q  <= '0;
      pat_high_q <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[4:3])
        REG_LENGTH: pat_len_q  <= pwdata[LEN_W-1:0];
        REG_LOW:    pat_low_q  <= pwdata;
        REG_HIGH:   pat_high_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      REG_LENGTH: prdata = DATA_W'(pat_len_q);
      REG_LOW:    prdata = pat_low_q;
      REG_HIGH:   prdata = pat_high_q;
      default:    prdata = '0;
    endcase
  end

  // A length of zero acts as one, anything beyond the chain as its full length.
  len_t len_eff;
  always_comb begin
    priority if (pat_len_q == '0) begin
      len_eff = len_t'(1);
    end else if (pat_len_q > len_t'(MAX_PATTERN)) begin
      len_eff = len_t'(MAX_PATTERN);
    end else begin
      len_eff = pat_len_q;
    end
  end

  // Cell i holds the byte that arrived i items ago, so it is compared with
  // pattern byte len-1-i. Cells at or beyond the length are masked off.
  logic [2*PAT_W-1:0]     pat_all;
  byte_t                  pat_cell [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] in_use;

  assign pat_all = {pat_high_q, pat_low_q};

  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      len_t k;
      k           = len_eff - len_t'(i) - len_t'(1);
      pat_cell[i] = pat_all[k[3:0]*BYTE_W +: BYTE_W];
      in_use[i]   = (len_t'(i) < len_eff);
    end
  end

  // ---------------------------------------------------------------------
  // Handshake and line control.
  // ---------------------------------------------------------------------
  logic  in_fire;
  logic  is_newline;
  logic  shift;
  logic  found_q, found_d;
  line_t line_q, line_d;
  logic  out_valid_q, out_valid_d;
  line_t out_line_q;
  logic  match;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_newline = (text_byte_i == NEWLINE_BYTE);
  assign shift      = in_fire && !is_newline;

  // ---------------------------------------------------------------------
  // Cell chain. Every accepted text byte but a newline enters cell 0 and
  // each cell hands its byte and valid bit on to the next one. A newline drops
  // all valid bits, which hides the old window contents from the compare.
  // ---------------------------------------------------------------------
  byte_t                  chain_byte  [MAX_PATTERN+1];
  logic [MAX_PATTERN:0]   chain_valid;
  cell_status_t           status      [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] hit_or_unused;

  assign chain_byte[0]  = text_byte_i;
  assign chain_valid[0] = 1'b1;

  for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
    lsm_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (shift),
      .clear_i  (in_fire && is_newline),
      .byte_i   (chain_byte[g]),
      .valid_i  (chain_valid[g]),
      .pat_i    (pat_cell[g]),
      .byte_o   (chain_byte[g+1]),
      .valid_o  (chain_valid[g+1]),
      .status_o (status[g])
    );
    assign hit_or_unused[g] = (status[g].valid && status[g].eq) || !in_use[g];
  end

  // The last byte of the chain falls off the end and is not needed.
  byte_t unused_tail;
  logic  unused_tail_valid;
  assign unused_tail       = chain_byte[MAX_PATTERN];
  assign unused_tail_valid = chain_valid[MAX_PATTERN];

  assign match = shift && !found_q && (&hit_or_unused);

  always_comb begin
    found_d = found_q;
    line_d  = line_q;
    if (in_fire && is_newline) begin
      found_d = 1'b0;
      if (line_q != '1) begin
        line_d = line_q + line_t'(1);
      end
    end else if (match) begin
      found_d = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (match) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q     <= 1'b0;
      line_q      <= line_t'(1);
      out_valid_q <= 1'b0;
    end else begin
      found_q     <= found_d;
      line_q      <= line_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (match) begin
      out_line_q <= line_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign line_number_o = out_line_q;

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  `LSM_ASSERT(a_result_sets_found, $rose(out_valid_q) |-> found_q,
              "result issued without the found flag set")
  `LSM_ASSERT(a_newline_clears, (in_fire && is_newline) |=> (!found_q && !chain_valid[1]),
              "newline did not clear the found flag and window")
  `LSM_ASSERT(a_line_nonzero, line_q != '0, "line number reached zero")
  `LSM_ASSERT(a_stall_blocks_input, (out_valid_q && !out_ready_i) |-> !in_ready_o,
              "input taken while a result is stalled")

endmodule

`default_nettype wire
